// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers for the divider word encoder. Each use is clocked,
// held off during reset and reports through $error.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define PDWE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the following cycle.
`define PDWE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Antecedent implies consequent a fixed number of cycles later.
`define PDWE_ASSERT_DELAY(label, clk, rst, ante, n, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/pdwe_pkg.sv
// ----------------------------------------------------------------------------
// Divider word encoder package
// Widths, frequency constants, division reciprocals, bit tables of the
// scrambled divider word, and the types shared between the modules.
// ----------------------------------------------------------------------------
package pdwe_pkg;

   // Widths of the datapath.
   localparam int FreqW      = 30;
   localparam int WordW      = 16;
   localparam int IndexW     = 2;
   localparam int QuotW      = 18;
   localparam int RemW       = 15;
   localparam int StepW      = 14;
   localparam int RecipW     = 32;
   localparam int RecipShift = 44;
   localparam int UpperSteps = 7;
   localparam int LowerSteps = 7;
   localparam int LowerW     = 7;

   // Register indexes of the configuration port.
   localparam logic [IndexW-1:0] RegRxFrequency = 2'd0;
   localparam logic [IndexW-1:0] RegTxFrequency = 2'd1;

   // Frequencies in hertz.
   localparam logic [FreqW-1:0] FreqReset   = 30'd145500000;
   localparam logic [FreqW-1:0] IfOffset    = 30'd21400000;
   localparam logic [FreqW-1:0] IfSplit     = 30'd100000000;
   localparam logic [FreqW-1:0] WideStepMin = 30'd110000000;

   // Channel steps.
   localparam logic [StepW-1:0] StepA = 14'd12500;
   localparam logic [StepW-1:0] StepB = 14'd10000;
   localparam logic [StepW-1:0] StepC = 14'd5000;

   // Scaled reciprocals: the quotient estimate is at most one too small.
   localparam logic [RecipW-1:0] RecipA = RecipW'((64'd1 << RecipShift) / 64'd12500);
   localparam logic [RecipW-1:0] RecipB = RecipW'((64'd1 << RecipShift) / 64'd10000);
   localparam logic [RecipW-1:0] RecipC = RecipW'((64'd1 << RecipShift) / 64'd5000);

   // Chain constants.
   localparam logic [RemW-1:0]   BaseOffset   = 15'd25600;
   localparam logic [LowerW-1:0] FineWeight   = 7'd100;
   localparam logic [WordW-1:0]  BitHalfStep  = 16'h1000;
   localparam logic [WordW-1:0]  BitFine      = 16'h0010;

   localparam logic [StepW-1:0] UpperWeight [UpperSteps] =
      '{14'd12800, 14'd6400, 14'd3200, 14'd1600, 14'd800, 14'd400, 14'd200};
   localparam logic [WordW-1:0] UpperBit [UpperSteps] =
      '{16'h2000, 16'h4000, 16'h8000, 16'h0100, 16'h0200, 16'h0400, 16'h0800};
   localparam logic [LowerW-1:0] LowerWeight [LowerSteps] =
      '{7'd64, 7'd32, 7'd16, 7'd8, 7'd4, 7'd2, 7'd1};
   localparam logic [WordW-1:0] LowerBit [LowerSteps] =
      '{16'h0020, 16'h0040, 16'h0080, 16'h0004, 16'h0008, 16'h0002, 16'h0001};

   // Queue status seen by the front and back parts.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// File: hw/rtl/pdwe_front.sv
// ----------------------------------------------------------------------------
// Divider word encoder front part
// Holds the frequency registers, accepts requests and forms the working
// frequency, shifted by the intermediate frequency in receive mode.
// ----------------------------------------------------------------------------
module pdwe_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_receive_mode,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pdwe_pkg::IndexW-1:0]         csr_index,
   input  logic [pdwe_pkg::FreqW-1:0]          csr_wdata,
   input  pdwe_pkg::queue_status_type          qstat,
   output logic                                push,
   output logic [pdwe_pkg::FreqW-1:0]          push_freq
);

   logic [pdwe_pkg::FreqW-1:0] rx_freq_ff;
   logic [pdwe_pkg::FreqW-1:0] tx_freq_ff;
   logic [pdwe_pkg::FreqW-1:0] rx_shifted;

   // Register writes are always taken; unknown indexes are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_freq_ff <= pdwe_pkg::FreqReset;
         tx_freq_ff <= pdwe_pkg::FreqReset;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            pdwe_pkg::RegRxFrequency: rx_freq_ff <= csr_wdata;
            pdwe_pkg::RegTxFrequency: tx_freq_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The intermediate frequency is subtracted above the split and added below.
   always_comb begin
      if (rx_freq_ff > pdwe_pkg::IfSplit) begin
         rx_shifted = rx_freq_ff - pdwe_pkg::IfOffset;
      end else begin
         rx_shifted = rx_freq_ff + pdwe_pkg::IfOffset;
      end
   end

   // A request is taken whenever the queue has room.
   assign busy      = qstat.full;
   assign push      = start && !busy;
   assign push_freq = req_receive_mode ? rx_shifted : tx_freq_ff;

endmodule

// File: hw/rtl/pdwe_queue.sv
// ----------------------------------------------------------------------------
// Divider word encoder queue
// A short first-in first-out buffer of working frequencies between the
// front and back parts.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pdwe_queue #(
   parameter int Depth = 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [pdwe_pkg::FreqW-1:0]    push_freq,
   input  logic                          pop,
   output logic [pdwe_pkg::FreqW-1:0]    head_freq,
   output pdwe_pkg::queue_status_type    qstat
);

   localparam int PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountW = $clog2(Depth + 1);

   logic [pdwe_pkg::FreqW-1:0] slot_ff [Depth];
   logic [PtrW-1:0]            wr_ptr_ff;
   logic [PtrW-1:0]            wr_ptr_in;
   logic [PtrW-1:0]            rd_ptr_ff;
   logic [PtrW-1:0]            rd_ptr_in;
   logic [CountW-1:0]          count_ff;
   logic [CountW-1:0]          count_in;

   // Pointer and count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_freq;
      end
   end

   assign head_freq   = slot_ff[rd_ptr_ff];
   assign qstat.full  = (count_ff == CountW'(Depth));
   assign qstat.empty = (count_ff == '0);

   `PDWE_ASSERT_IMPL(a_no_overflow, clock, reset, push, !qstat.full || pop, "queue overflow")
   `PDWE_ASSERT_IMPL(a_no_underflow, clock, reset, pop, !qstat.empty, "queue underflow")

endmodule

// File: hw/rtl/pdwe_back.sv
// ----------------------------------------------------------------------------
// Divider word encoder back part
// Five-stage pipeline: reciprocal quotient estimates, remainders, step
// selection, then the compare-subtract chain in two halves.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pdwe_back (
   input  logic                          clock,
   input  logic                          reset,
   input  pdwe_pkg::queue_status_type    qstat,
   input  logic [pdwe_pkg::FreqW-1:0]    head_freq,
   output logic                          pop,
   output logic                          rsp_strobe,
   output logic [pdwe_pkg::WordW-1:0]    rsp_pll_word
);

   localparam int ProdW = pdwe_pkg::FreqW + pdwe_pkg::RecipW;

   // Stage one: quotient estimates.
   logic                        s1_valid_ff;
   logic [pdwe_pkg::FreqW-1:0]  s1_freq_ff;
   logic                        s1_wide_ff;
   logic [pdwe_pkg::QuotW-1:0]  s1_qa_ff;
   logic [pdwe_pkg::QuotW-1:0]  s1_qb_ff;
   logic [pdwe_pkg::QuotW-1:0]  s1_qc_ff;
   logic [ProdW-1:0]            prod_a;
   logic [ProdW-1:0]            prod_b;
   logic [ProdW-1:0]            prod_c;

   // Stage two: remainders.
   logic                        s2_valid_ff;
   logic [pdwe_pkg::FreqW-1:0]  s2_freq_ff;
   logic                        s2_wide_ff;
   logic [pdwe_pkg::QuotW-1:0]  s2_qa_ff;
   logic [pdwe_pkg::QuotW-1:0]  s2_qb_ff;
   logic [pdwe_pkg::QuotW-1:0]  s2_qc_ff;
   logic [pdwe_pkg::RemW-1:0]   s2_ra_ff;
   logic [pdwe_pkg::RemW-1:0]   s2_rb_ff;
   logic [pdwe_pkg::RemW-1:0]   s2_rc_ff;
   logic [pdwe_pkg::FreqW-1:0]  back_a;
   logic [pdwe_pkg::FreqW-1:0]  back_b;
   logic [pdwe_pkg::FreqW-1:0]  back_c;
   logic [pdwe_pkg::FreqW-1:0]  rem_a;
   logic [pdwe_pkg::FreqW-1:0]  rem_b;
   logic [pdwe_pkg::FreqW-1:0]  rem_c;

   // Stage three: chain input.
   logic                        s3_valid_ff;
   logic [pdwe_pkg::FreqW-1:0]  s3_value_ff;
   logic                        s3_half_ff;
   logic [pdwe_pkg::WordW-1:0]  s3_word_ff;
   logic [pdwe_pkg::FreqW-1:0]  s3_value_in;
   logic                        s3_half_in;
   logic [pdwe_pkg::WordW-1:0]  s3_word_in;
   logic                        hit_a;
   logic                        hit_b;
   logic                        hit_c;
   logic [pdwe_pkg::QuotW-1:0]  quot_a;
   logic [pdwe_pkg::QuotW-1:0]  quot_b;
   logic [pdwe_pkg::QuotW-1:0]  quot_c;

   // Stage four: offset and upper chain.
   logic                        s4_valid_ff;
   logic [pdwe_pkg::FreqW-1:0]  s4_value_ff;
   logic                        s4_half_ff;
   logic [pdwe_pkg::WordW-1:0]  s4_word_ff;
   logic [pdwe_pkg::FreqW-1:0]  s4_value_in;
   logic [pdwe_pkg::WordW-1:0]  s4_word_in;
   logic [pdwe_pkg::FreqW-1:0]  offset;

   // Stage five: fine bit and lower chain.
   logic                        rsp_strobe_ff;
   logic [pdwe_pkg::WordW-1:0]  rsp_word_ff;
   logic [pdwe_pkg::FreqW-1:0]  low_value;
   logic [pdwe_pkg::WordW-1:0]  rsp_word_in;

   // The back part never stalls, so the head is taken whenever present.
   assign pop = !qstat.empty;

   // Valid flags of the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         s4_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s1_valid_ff   <= pop;
         s2_valid_ff   <= s1_valid_ff;
         s3_valid_ff   <= s2_valid_ff;
         s4_valid_ff   <= s3_valid_ff;
         rsp_strobe_ff <= s4_valid_ff;
      end
   end

   // Quotient estimates by multiplication with scaled reciprocals.
   assign prod_a = ProdW'(head_freq) * ProdW'(pdwe_pkg::RecipA);
   assign prod_b = ProdW'(head_freq) * ProdW'(pdwe_pkg::RecipB);
   assign prod_c = ProdW'(head_freq) * ProdW'(pdwe_pkg::RecipC);

   always_ff @(posedge clock) begin
      s1_freq_ff <= head_freq;
      s1_wide_ff <= (head_freq > pdwe_pkg::WideStepMin);
      s1_qa_ff   <= prod_a[pdwe_pkg::RecipShift +: pdwe_pkg::QuotW];
      s1_qb_ff   <= prod_b[pdwe_pkg::RecipShift +: pdwe_pkg::QuotW];
      s1_qc_ff   <= prod_c[pdwe_pkg::RecipShift +: pdwe_pkg::QuotW];
   end

   // Remainders of the estimates; each lies below twice its step.
   assign back_a = pdwe_pkg::FreqW'(s1_qa_ff) * pdwe_pkg::FreqW'(pdwe_pkg::StepA);
   assign back_b = pdwe_pkg::FreqW'(s1_qb_ff) * pdwe_pkg::FreqW'(pdwe_pkg::StepB);
   assign back_c = pdwe_pkg::FreqW'(s1_qc_ff) * pdwe_pkg::FreqW'(pdwe_pkg::StepC);
   assign rem_a  = s1_freq_ff - back_a;
   assign rem_b  = s1_freq_ff - back_b;
   assign rem_c  = s1_freq_ff - back_c;

   always_ff @(posedge clock) begin
      s2_freq_ff <= s1_freq_ff;
      s2_wide_ff <= s1_wide_ff;
      s2_qa_ff   <= s1_qa_ff;
      s2_qb_ff   <= s1_qb_ff;
      s2_qc_ff   <= s1_qc_ff;
      s2_ra_ff   <= rem_a[pdwe_pkg::RemW-1:0];
      s2_rb_ff   <= rem_b[pdwe_pkg::RemW-1:0];
      s2_rc_ff   <= rem_c[pdwe_pkg::RemW-1:0];
   end

   // Correct the estimates and pick the channel step.
   always_comb begin
      hit_a  = (s2_ra_ff == '0) || (s2_ra_ff == pdwe_pkg::RemW'(pdwe_pkg::StepA));
      hit_b  = (s2_rb_ff == '0) || (s2_rb_ff == pdwe_pkg::RemW'(pdwe_pkg::StepB));
      hit_c  = (s2_rc_ff == '0) || (s2_rc_ff == pdwe_pkg::RemW'(pdwe_pkg::StepC));
      quot_a = s2_qa_ff + pdwe_pkg::QuotW'(s2_ra_ff >= pdwe_pkg::RemW'(pdwe_pkg::StepA));
      quot_b = s2_qb_ff + pdwe_pkg::QuotW'(s2_rb_ff >= pdwe_pkg::RemW'(pdwe_pkg::StepB));
      quot_c = s2_qc_ff + pdwe_pkg::QuotW'(s2_rc_ff >= pdwe_pkg::RemW'(pdwe_pkg::StepC));
      if (hit_a && s2_wide_ff) begin
         s3_value_in = pdwe_pkg::FreqW'(quot_a);
         s3_half_in  = 1'b0;
         s3_word_in  = '0;
      end else if (hit_b && s2_wide_ff) begin
         s3_value_in = pdwe_pkg::FreqW'(quot_b);
         s3_half_in  = 1'b0;
         s3_word_in  = pdwe_pkg::BitHalfStep;
      end else if (hit_c) begin
         s3_value_in = pdwe_pkg::FreqW'(quot_c);
         s3_half_in  = 1'b1;
         s3_word_in  = pdwe_pkg::BitHalfStep;
      end else begin
         s3_value_in = s2_freq_ff;
         s3_half_in  = 1'b0;
         s3_word_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      s3_value_ff <= s3_value_in;
      s3_half_ff  <= s3_half_in;
      s3_word_ff  <= s3_word_in;
   end

   // Offset removal and the upper weights, halved for the five kilohertz step.
   always_comb begin
      s4_value_in = s3_value_ff;
      s4_word_in  = s3_word_ff;
      offset      = pdwe_pkg::FreqW'(pdwe_pkg::BaseOffset >> s3_half_ff);
      if (s4_value_in >= offset) begin
         s4_value_in = s4_value_in - offset;
      end
      for (int i = 0; i < pdwe_pkg::UpperSteps; i++) begin
         if (s4_value_in >= pdwe_pkg::FreqW'(pdwe_pkg::UpperWeight[i] >> s3_half_ff)) begin
            s4_word_in  = s4_word_in | pdwe_pkg::UpperBit[i];
            s4_value_in = s4_value_in
                        - pdwe_pkg::FreqW'(pdwe_pkg::UpperWeight[i] >> s3_half_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      s4_value_ff <= s4_value_in;
      s4_half_ff  <= s3_half_ff;
      s4_word_ff  <= s4_word_in;
   end

   // Fine bit, always set on the half chain, then the lower weights.
   always_comb begin
      low_value   = s4_value_ff;
      rsp_word_in = s4_word_ff;
      if (s4_half_ff) begin
         rsp_word_in = rsp_word_in | pdwe_pkg::BitFine;
      end else if (low_value >= pdwe_pkg::FreqW'(pdwe_pkg::FineWeight)) begin
         rsp_word_in = rsp_word_in | pdwe_pkg::BitFine;
         low_value   = low_value - pdwe_pkg::FreqW'(pdwe_pkg::FineWeight);
      end
      for (int i = 0; i < pdwe_pkg::LowerSteps; i++) begin
         if (low_value >= pdwe_pkg::FreqW'(pdwe_pkg::LowerWeight[i])) begin
            rsp_word_in = rsp_word_in | pdwe_pkg::LowerBit[i];
            low_value   = low_value - pdwe_pkg::FreqW'(pdwe_pkg::LowerWeight[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_pll_word = rsp_word_ff;

   `PDWE_ASSERT_IMPL(a_strobe_from_pop, clock, reset, rsp_strobe, $past(pop, 5), "word without request")

endmodule

// File: hw/rtl/pll_divider_word_encoder.sv
// The word is strobed once the accepted request has passed the queue and the back pipeline stages.
// Throughput: one word per cycle, set by the five-stage back pipeline, which never stalls.
// busy reflects a full queue; as the back part drains a word every cycle it stays low.
// Reset (synchronous, active high) empties the queue and pipeline and sets both
// frequency registers to 145.5 MHz.
// ----------------------------------------------------------------------------
// Synthesizer divider word encoder
// Front part forms the working frequency, a short queue decouples it from the
// back pipeline that divides by the channel step and builds the divider word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pll_divider_word_encoder #(
   parameter int QueueDepth = 2
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_receive_mode,
   output logic                                rsp_strobe,
   output logic [pdwe_pkg::WordW-1:0]          rsp_pll_word,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pdwe_pkg::IndexW-1:0]         csr_index,
   input  logic [pdwe_pkg::FreqW-1:0]          csr_wdata
);

   localparam int Latency = 6;

   pdwe_pkg::queue_status_type  qstat;
   logic                        push;
   logic [pdwe_pkg::FreqW-1:0]  push_freq;
   logic                        pop;
   logic [pdwe_pkg::FreqW-1:0]  head_freq;

   // Request side and frequency registers.
   pdwe_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_receive_mode (req_receive_mode),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .qstat            (qstat),
      .push             (push),
      .push_freq        (push_freq)
   );

   // Buffer of working frequencies.
   pdwe_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_freq (push_freq),
      .pop       (pop),
      .head_freq (head_freq),
      .qstat     (qstat)
   );

   // Division and word assembly.
   pdwe_back u_back (
      .clock        (clock),
      .reset        (reset),
      .qstat        (qstat),
      .head_freq    (head_freq),
      .pop          (pop),
      .rsp_strobe   (rsp_strobe),
      .rsp_pll_word (rsp_pll_word)
   );

   `PDWE_ASSERT_DELAY(a_fixed_latency, clock, reset, start && !busy, Latency, rsp_strobe, "word late or missing")

endmodule

// File: tb/tb_pll_divider_word_encoder.sv
// ----------------------------------------------------------------------------
// Divider word encoder testbench
// Loads receive and transmit frequencies through the register port, sends
// receive and transmit requests in bursts, some with random gaps, and checks every
// strobed divider word against an independent model of the encoding.
// ----------------------------------------------------------------------------
module tb_pll_divider_word_encoder;
   timeunit 1ns;
   timeprecision 1ps;

   // Request sense levels and the register indexes that decode to nothing.
   localparam bit ModeReceive  = 1'b1;
   localparam bit ModeTransmit = 1'b0;
   localparam logic [pdwe_pkg::IndexW-1:0] SpareIndexLo = 2'd2;
   localparam logic [pdwe_pkg::IndexW-1:0] SpareIndexHi = 2'd3;

   // Frequency plan of the radio, in hertz.
   localparam int unsigned IfShiftHz   = 21400000;
   localparam int unsigned IfSplitHz   = 100000000;
   localparam int unsigned WideStepHz  = 110000000;
   localparam int unsigned MaxFreqHz   = 1000000000;
   localparam int unsigned ResetFreqHz = 145500000;

   // Bit positions of the scrambled word, coarse weights then fine weights.
   localparam logic [15:0] CoarseBits [7] =
      '{16'h2000, 16'h4000, 16'h8000, 16'h0100, 16'h0200, 16'h0400, 16'h0800};
   localparam int unsigned FineWeights [7] = '{64, 32, 16, 8, 4, 2, 1};
   localparam logic [15:0] FineBits [7] =
      '{16'h0020, 16'h0040, 16'h0080, 16'h0004, 16'h0008, 16'h0002, 16'h0001};
   localparam logic [15:0] HalfStepBit = 16'h1000;
   localparam logic [15:0] HundredBit  = 16'h0010;

   // Holds the register copies and the words still owed by the block.
   class word_scoreboard;
      logic [pdwe_pkg::FreqW-1:0] rx_freq;
      logic [pdwe_pkg::FreqW-1:0] tx_freq;
      logic [pdwe_pkg::WordW-1:0] owed_words [$];
      int errors;
      int checked;
      int rx_items;
      int tx_items;
      int writes;

      function new();
         rx_freq  = pdwe_pkg::FreqW'(ResetFreqHz);
         tx_freq  = pdwe_pkg::FreqW'(ResetFreqHz);
         errors   = 0;
         checked  = 0;
         rx_items = 0;
         tx_items = 0;
         writes   = 0;
      endfunction

      // Encodes a working frequency into the synthesiser divider word.
      function logic [pdwe_pkg::WordW-1:0] divider_word(int unsigned f);
         logic [pdwe_pkg::WordW-1:0] w;
         int unsigned half;
         int unsigned wt;
         w    = '0;
         half = 0;
         if (f % 12500 == 0 && f > WideStepHz) begin
            f = f / 12500;
         end else if (f % 10000 == 0 && f > WideStepHz) begin
            w = w | HalfStepBit;
            f = f / 10000;
         end else if (f % 5000 == 0) begin
            w    = w | HalfStepBit;
            f    = f / 5000;
            half = 1;
         end
         if (f >= (25600 >> half)) f = f - (25600 >> half);
         for (int i = 0; i < 7; i++) begin
            wt = (12800 >> i) >> half;
            if (f >= wt) begin
               w = w | CoarseBits[i];
               f = f - wt;
            end
         end
         // The hundred bit is conditional on the full chain only.
         if (half != 0) begin
            w = w | HundredBit;
         end else if (f >= 100) begin
            w = w | HundredBit;
            f = f - 100;
         end
         for (int i = 0; i < 7; i++) begin
            if (f >= FineWeights[i]) begin
               w = w | FineBits[i];
               f = f - FineWeights[i];
            end
         end
         return w;
      endfunction

      function void note_write(logic [pdwe_pkg::IndexW-1:0] idx,
                               logic [pdwe_pkg::FreqW-1:0] data);
         writes++;
         case (idx)
            pdwe_pkg::RegRxFrequency: rx_freq = data;
            pdwe_pkg::RegTxFrequency: tx_freq = data;
            default: ;
         endcase
      endfunction

      // Works out the word owed for a request accepted with the current registers.
      function void note_request(bit mode);
         int unsigned f;
         if (mode == ModeReceive) begin
            f = rx_freq;
            if (f > IfSplitHz) f = f - IfShiftHz;
            else f = f + IfShiftHz;
            rx_items++;
         end else begin
            f = tx_freq;
            tx_items++;
         end
         owed_words.push_back(divider_word(f));
      endfunction

      function void check_word(logic [pdwe_pkg::WordW-1:0] got);
         logic [pdwe_pkg::WordW-1:0] want;
         if (owed_words.size() == 0) begin
            errors++;
            $display("%0t ns: unexpected word, expected none, actual %h", $time, got);
            return;
         end
         want = owed_words.pop_front();
         checked++;
         if (got !== want) begin
            errors++;
            $display("%0t ns: pll_word mismatch, expected %h, actual %h", $time, want, got);
         end
      endfunction
   endclass

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic                        req_receive_mode;
   logic                        rsp_strobe;
   logic [pdwe_pkg::WordW-1:0]  rsp_pll_word;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [pdwe_pkg::IndexW-1:0] csr_index;
   logic [pdwe_pkg::FreqW-1:0]  csr_wdata;

   word_scoreboard sb = new();
   int random_items;

   pll_divider_word_encoder DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_receive_mode (req_receive_mode),
      .rsp_strobe       (rsp_strobe),
      .rsp_pll_word     (rsp_pll_word),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Every strobed word is checked at the edge that ends its cycle.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_word(rsp_pll_word);
   end

   // Writes one register and waits for the port to take the word.
   task automatic write_reg(logic [pdwe_pkg::IndexW-1:0] idx,
                            logic [pdwe_pkg::FreqW-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      sb.note_write(idx, data);
   endtask

   task automatic end_writes();
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Offers one request word and waits until the block accepts it.
   task automatic send_item(bit mode);
      @(negedge clock);
      start            <= 1'b1;
      req_receive_mode <= mode;
      do @(posedge clock); while (busy);
      sb.note_request(mode);
   endtask

   // Holds start low for a rest, with noise on the ignored sense level.
   task automatic rest_cycles(int n);
      @(negedge clock);
      start            <= 1'b0;
      req_receive_mode <= 1'($urandom);
      repeat (n - 1) @(negedge clock);
   endtask

   // Stops sending and waits until every owed word has come back.
   task automatic quiesce();
      @(negedge clock);
      start <= 1'b0;
      while (sb.owed_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic directed_pair(int unsigned rx, int unsigned tx);
      quiesce();
      write_reg(pdwe_pkg::RegRxFrequency, pdwe_pkg::FreqW'(rx));
      write_reg(pdwe_pkg::RegTxFrequency, pdwe_pkg::FreqW'(tx));
      end_writes();
      send_item(ModeReceive);
      send_item(ModeTransmit);
   endtask

   // Draws a frequency from one of the step classes, near a boundary, or at random.
   function automatic int unsigned pick_frequency();
      int unsigned edges [5] = '{100000000, 110000000, 131400000, 78600000, 88600000};
      int unsigned f;
      case ($urandom_range(0, 6))
         0: f = $urandom_range(8801, 80000) * 12500;
         1: f = $urandom_range(11001, 100000) * 10000;
         2: f = $urandom_range(0, 200000) * 5000;
         3: f = $urandom_range(0, 22000) * 5000;
         4: f = $urandom_range(0, MaxFreqHz);
         5: begin
            f = edges[$urandom_range(0, 4)] + $urandom_range(0, 2) * 5000;
            if ($urandom_range(0, 3) == 0) f = f + $urandom_range(1, 3);
         end
         default: f = $urandom_range(0, 300000);
      endcase
      return f;
   endfunction

   // Main sequence: reset, directed settings, then random phases.
   initial begin
      int count;
      int burst;
      bit steady;
      bit wrote;
      reset            = 1'b1;
      start            = 1'b0;
      req_receive_mode = 1'b0;
      csr_valid        = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      random_items     = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Registers as they come out of reset.
      send_item(ModeReceive);
      send_item(ModeTransmit);

      // Zero, the top of the range, and the split and wide-step boundaries.
      directed_pair(0, 0);
      directed_pair(MaxFreqHz, MaxFreqHz);
      directed_pair(100000000, 110000000);
      directed_pair(100000001, 110012500);
      directed_pair(131400000, 110010000);
      directed_pair(131412500, 110005000);
      directed_pair(123456789, 1);
      directed_pair(5000, 999999999);

      // Writes to unused indexes must leave both registers alone.
      quiesce();
      write_reg(SpareIndexLo, '1);
      write_reg(SpareIndexHi, '1);
      end_writes();
      send_item(ModeReceive);
      send_item(ModeTransmit);

      // Random phases: new settings while idle, then bursts of requests.
      while (random_items < 380) begin
         quiesce();
         wrote = 1'b0;
         if ($urandom_range(0, 3) != 0) begin
            write_reg(pdwe_pkg::RegRxFrequency, pdwe_pkg::FreqW'(pick_frequency()));
            wrote = 1'b1;
         end
         if ($urandom_range(0, 3) != 0) begin
            write_reg(pdwe_pkg::RegTxFrequency, pdwe_pkg::FreqW'(pick_frequency()));
            wrote = 1'b1;
         end
         if ($urandom_range(0, 7) == 0) begin
            write_reg(pdwe_pkg::IndexW'($urandom_range(SpareIndexLo, SpareIndexHi)),
                      pdwe_pkg::FreqW'($urandom));
            wrote = 1'b1;
         end
         if (wrote) end_writes();
         count  = $urandom_range(4, 16);
         steady = ($urandom_range(0, 3) == 0);
         burst  = $urandom_range(1, 8);
         for (int n = 0; n < count; n++) begin
            send_item(1'($urandom_range(0, 1)));
            random_items++;
            burst--;
            if (burst == 0 && !steady) begin
               rest_cycles($urandom_range(1, 6));
               burst = $urandom_range(1, 8);
            end
         end
      end

      quiesce();
      $display("Checked %0d words from %0d receive and %0d transmit requests,",
               sb.checked, sb.rx_items, sb.tx_items);
      $display("across %0d register writes including unused indexes.", sb.writes);
      if (sb.errors == 0 && sb.owed_words.size() == 0) begin
         $display("** pll_divider_word_encoder: PASSED **");
      end else begin
         $display("** pll_divider_word_encoder: FAILED **");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #(2_000_000);
      $display("Timed out with %0d words still owed.", sb.owed_words.size());
      $display("** pll_divider_word_encoder: FAILED **");
      $finish;
   end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/pdwe_pkg.sv
hw/rtl/pdwe_front.sv
hw/rtl/pdwe_queue.sv
hw/rtl/pdwe_back.sv
hw/rtl/pll_divider_word_encoder.sv
tb/tb_pll_divider_word_encoder.sv
